/* rtl/core/dms_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dms_pkg: shared types and constants of the tissue signal model core.
// Fixed-point constants, sequencer states and requests to the arithmetic units.
// ----------------------------------------------------------------------------
package dms_pkg;

    localparam int unsigned CP_W      = 32;
    localparam int unsigned SIG_W     = 32;
    localparam int unsigned SUM_W     = 48;
    localparam int unsigned IDX_W     = 10;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 48;
    localparam int unsigned DIVS_W    = 33;

    localparam logic [63:0] ONE_Q60      = 64'h1000_0000_0000_0000;
    localparam logic [63:0] X_ZERO_LIMIT = 64'd24 << 32;
    localparam logic [4:0]  EXP_TERMS    = 5'd20;
    localparam logic [31:0] SIGNAL_ONE   = 32'h0100_0000;
    localparam logic [IDX_W-1:0] PRE_COUNT_MAX = 10'd1023;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_DECAY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUM_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOW_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_RATE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COS_FLIP  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PRE_COUNT = 3'd6;

    typedef enum logic [1:0] {
        SH_24,
        SH_32,
        SH_40,
        SH_60
    } shift_t;

    typedef struct packed {
        logic   start;
        shift_t sh;
    } mul_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_XS_MUL,
        ST_XN_MUL,
        ST_EXP_INIT,
        ST_EXP_MUL,
        ST_EXP_DIV,
        ST_POW_MUL,
        ST_DEN_MUL,
        ST_RATIO,
        ST_RATIO_DIV,
        ST_SIG_MUL,
        ST_SUM_MUL,
        ST_DONE
    } state_t;

endpackage

/* rtl/core/dms_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dms_mul: shared 64x64 multiplier with right shift and saturation.
// Four 32x32 partial products go through one multiplier, one per cycle.
// ----------------------------------------------------------------------------
module dms_mul import dms_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  mul_req_t    req,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output unit_stat_t  stat,
    output logic [63:0] result
);

    logic [2:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [63:0]  a_reg, a_next, b_reg, b_next;
    shift_t       sh_reg, sh_next;
    logic [63:0]  prod_reg, prod_next;
    logic [127:0] acc_reg, acc_next;
    logic [31:0]  ma, mb;
    logic [127:0] addend;
    logic [127:0] shifted;

    always_comb begin
        case (cnt_reg[1:0])
            2'd0: begin ma = a_reg[31:0];  mb = b_reg[31:0];  end
            2'd1: begin ma = a_reg[31:0];  mb = b_reg[63:32]; end
            2'd2: begin ma = a_reg[63:32]; mb = b_reg[31:0];  end
            default: begin ma = a_reg[63:32]; mb = b_reg[63:32]; end
        endcase
        // Offset of the product taken in the previous cycle.
        case (cnt_reg)
            3'd1: addend = {64'd0, prod_reg};
            3'd2: addend = {32'd0, prod_reg, 32'd0};
            3'd3: addend = {32'd0, prod_reg, 32'd0};
            3'd4: addend = {prod_reg, 64'd0};
            default: addend = 128'd0;
        endcase
    end

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        a_next    = a_reg;
        b_next    = b_reg;
        sh_next   = sh_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        if (req.start) begin
            a_next    = op_a;
            b_next    = op_b;
            sh_next   = req.sh;
            acc_next  = 128'd0;
            cnt_next  = 3'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            prod_next = {32'd0, ma} * {32'd0, mb};
            acc_next  = acc_reg + addend;
            cnt_next  = cnt_reg + 3'd1;
            if (cnt_reg == 3'd4) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        a_reg    <= a_next;
        b_reg    <= b_next;
        sh_reg   <= sh_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    always_comb begin
        case (sh_reg)
            SH_24:   shifted = acc_reg >> 24;
            SH_32:   shifted = acc_reg >> 32;
            SH_40:   shifted = acc_reg >> 40;
            default: shifted = acc_reg >> 60;
        endcase
        result = (shifted[127:64] != 64'd0) ? {64{1'b1}} : shifted[63:0];
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* rtl/core/dms_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dms_div: restoring divider, 64-bit dividend by 33-bit divisor.
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module dms_div import dms_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [63:0]       dividend,
    input  logic [DIVS_W-1:0] divisor,
    output unit_stat_t        stat,
    output logic [63:0]       quotient
);

    logic [5:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [63:0]       quo_reg, quo_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVS_W-1:0] dvs_reg, dvs_next;
    logic [DIVS_W:0]   trial;

    always_comb begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[63]};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = DIVS_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[62:0], 1'b1};
            end else begin
                rem_next = trial[DIVS_W-1:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

/* rtl/core/dce_mri_signal_model.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dce_mri_signal_model: extended Tofts tissue model with SPGR signal.
// Maps plasma concentration samples to normalized signal in fixed point.
// ----------------------------------------------------------------------------
// Usage: the host writes the model registers on the cfg channel while the
// block is idle. Samples arrive on the s_ stream (cp in tdata, start_series in
// tuser); every sample gives one result on the m_ stream (signal in tdata,
// saturated flag in tuser). The block takes one sample at a time.
// A pre-injection sample skips the model and goes through ST_DONE to the
// output register. A modelled sample runs two 20-term exponential series,
// each step one pass through the shared 64x64 multiplier and the divider,
// plus up to 23 multiplies for the integer part of the exponent and at most
// one division for the signal ratio. An exponent of 24 or more skips both
// series. Reset clears the running sum, the sample count and the other
// configuration registers, and sets the pre-injection count to 5. A finished
// result waits in the output register while the receiver stalls; the next
// sample is taken meanwhile, and its result waits until the output register
// is free.
// ----------------------------------------------------------------------------
module dce_mri_signal_model import dms_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [CP_W-1:0]      s_tdata,   // [31:0] cp
    input  logic                 s_tuser,   // [0] start_series
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [SIG_W-1:0]     m_tdata,   // [31:0] signal
    output logic                 m_tuser,   // [0] saturated
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    // Configuration registers.
    logic [31:0]      decay_reg, base_rate_reg, cos_flip_reg;
    logic [39:0]      sum_gain_reg, now_gain_reg;
    logic [47:0]      scale_reg;
    logic [IDX_W-1:0] pre_count_reg;

    state_t            state_reg, state_next;
    logic              phase_reg, phase_next;
    logic [CP_W-1:0]   cp_reg, cp_next;
    logic [SUM_W-1:0]  rs_reg, rs_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [63:0]       x_reg, x_next;
    logic [63:0]       term_reg, term_next;
    logic [63:0]       acc_reg, acc_next;
    logic [63:0]       e1_reg, e1_next;
    logic [63:0]       e60_reg, e60_next;
    logic [4:0]        k_reg, k_next;
    logic              pass_reg, pass_next;
    logic [4:0]        whole_reg, whole_next;
    logic [32:0]       num32_reg, num32_next;
    logic [32:0]       den32_reg, den32_next;
    logic [32:0]       ratio_reg, ratio_next;
    logic [SIG_W-1:0]  sig_reg, sig_next;
    logic              sat_reg, sat_next;
    logic              m_valid_reg, m_valid_next;
    logic [SIG_W-1:0]  m_data_reg, m_data_next;
    logic              m_user_reg, m_user_next;

    mul_req_t          mul_req;
    unit_stat_t        mul_stat, div_stat;
    logic [63:0]       mul_a, mul_b, mul_res;
    logic              div_start;
    logic [63:0]       div_dvd, div_quo;
    logic [DIVS_W-1:0] div_dvs;

    logic [IDX_W-1:0]  idx_eff, limit;
    logic [64:0]       xsum;
    logic [63:0]       exp_arg, e_cl, acc_upd, den_full;
    logic [SUM_W:0]    rs_plus;
    logic [63:0]       num_full;

    dms_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mul_req),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .stat    (mul_stat),
        .result  (mul_res)
    );

    dms_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decay_reg     <= '0;
            sum_gain_reg  <= '0;
            now_gain_reg  <= '0;
            base_rate_reg <= '0;
            cos_flip_reg  <= '0;
            scale_reg     <= '0;
            pre_count_reg <= 10'd5;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_DECAY:     decay_reg     <= cfg_data[31:0];
                REG_SUM_GAIN:  sum_gain_reg  <= cfg_data[39:0];
                REG_NOW_GAIN:  now_gain_reg  <= cfg_data[39:0];
                REG_BASE_RATE: base_rate_reg <= cfg_data[31:0];
                REG_COS_FLIP:  cos_flip_reg  <= cfg_data[31:0];
                REG_SCALE:     scale_reg     <= cfg_data[47:0];
                REG_PRE_COUNT: pre_count_reg <= cfg_data[IDX_W-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    always_comb begin
        idx_eff  = s_tuser ? '0 : idx_reg;
        limit    = (pre_count_reg > PRE_COUNT_MAX) ? PRE_COUNT_MAX : pre_count_reg;
        xsum     = {1'b0, x_reg} + {1'b0, mul_res};
        exp_arg  = pass_reg ? {4'd0, x_reg[31:0], 28'd0} : ONE_Q60;
        e_cl     = (e60_reg > ONE_Q60) ? ONE_Q60 : e60_reg;
        num_full = ONE_Q60 - e_cl;
        den_full = ONE_Q60 - mul_res;
        rs_plus  = {1'b0, rs_reg} + {{(SUM_W+1-CP_W){1'b0}}, cp_reg};
        // Odd Taylor terms subtract with a floor at zero, even terms add.
        if (k_reg[0]) begin
            acc_upd = (div_quo > acc_reg) ? 64'd0 : acc_reg - div_quo;
        end else begin
            acc_upd = acc_reg + div_quo;
        end
    end

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        cp_next      = cp_reg;
        rs_next      = rs_reg;
        idx_next     = idx_reg;
        x_next       = x_reg;
        term_next    = term_reg;
        acc_next     = acc_reg;
        e1_next      = e1_reg;
        e60_next     = e60_reg;
        k_next       = k_reg;
        pass_next    = pass_reg;
        whole_next   = whole_reg;
        num32_next   = num32_reg;
        den32_next   = den32_reg;
        ratio_next   = ratio_reg;
        sig_next     = sig_reg;
        sat_next     = sat_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        mul_req      = '{start: 1'b0, sh: SH_60};
        mul_a        = term_reg;
        mul_b        = exp_arg;
        div_start    = 1'b0;
        div_dvd      = term_reg;
        div_dvs      = {28'd0, k_reg};

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                phase_next = 1'b0;
                if (s_tvalid) begin
                    cp_next  = s_tdata;
                    sat_next = 1'b0;
                    if (s_tuser) begin
                        rs_next = '0;
                    end
                    if (idx_eff < limit) begin
                        idx_next   = idx_eff + 10'd1;
                        sig_next   = SIGNAL_ONE;
                        state_next = ST_DONE;
                    end else begin
                        idx_next   = idx_eff;
                        x_next     = {32'd0, base_rate_reg};
                        state_next = ST_XS_MUL;
                    end
                end
            end
            ST_XS_MUL: begin
                mul_a = {24'd0, sum_gain_reg};
                mul_b = {16'd0, rs_reg};
                mul_req.sh = SH_24;
                if (!phase_reg) begin
                    mul_req.start = 1'b1;
                    phase_next    = 1'b1;
                end else if (mul_stat.done) begin
                    x_next     = xsum[64] ? {64{1'b1}} : xsum[63:0];
                    phase_next = 1'b0;
                    state_next = ST_XN_MUL;
                end
            end
            ST_XN_MUL: begin
                mul_a = {24'd0, now_gain_reg};
                mul_b = {32'd0, cp_reg};
                mul_req.sh = SH_24;
                if (!phase_reg) begin
                    mul_req.start = 1'b1;
                    phase_next    = 1'b1;
                end else if (mul_stat.done) begin
                    x_next     = xsum[64] ? {64{1'b1}} : xsum[63:0];
                    phase_next = 1'b0;
                    if (xsum[64] || xsum[63:0] >= X_ZERO_LIMIT) begin
                        e60_next   = 64'd0;
                        state_next = ST_DEN_MUL;
                    end else begin
                        pass_next  = 1'b0;
                        state_next = ST_EXP_INIT;
                    end
                end
            end
            ST_EXP_INIT: begin
                term_next  = ONE_Q60;
                acc_next   = ONE_Q60;
                k_next     = 5'd1;
                whole_next = x_reg[36:32];
                state_next = ST_EXP_MUL;
            end
            ST_EXP_MUL: begin
                if (!phase_reg) begin
                    mul_req.start = 1'b1;
                    phase_next    = 1'b1;
                end else if (mul_stat.done) begin
                    term_next  = mul_res;
                    phase_next = 1'b0;
                    state_next = ST_EXP_DIV;
                end
            end
            ST_EXP_DIV: begin
                if (!phase_reg) begin
                    div_start  = 1'b1;
                    phase_next = 1'b1;
                end else if (div_stat.done) begin
                    term_next  = div_quo;
                    acc_next   = acc_upd;
                    phase_next = 1'b0;
                    k_next     = k_reg + 5'd1;
                    if (k_reg != EXP_TERMS) begin
                        state_next = ST_EXP_MUL;
                    end else if (!pass_reg) begin
                        // First pass gives exp(-1) for the integer part.
                        e1_next    = acc_upd;
                        pass_next  = 1'b1;
                        state_next = ST_EXP_INIT;
                    end else begin
                        e60_next   = acc_upd;
                        state_next = (whole_reg == 5'd0) ? ST_DEN_MUL : ST_POW_MUL;
                    end
                end
            end
            ST_POW_MUL: begin
                mul_a = e60_reg;
                mul_b = e1_reg;
                if (!phase_reg) begin
                    mul_req.start = 1'b1;
                    phase_next    = 1'b1;
                end else if (mul_stat.done) begin
                    e60_next   = mul_res;
                    whole_next = whole_reg - 5'd1;
                    phase_next = 1'b0;
                    if (whole_reg == 5'd1) begin
                        state_next = ST_DEN_MUL;
                    end
                end
            end
            ST_DEN_MUL: begin
                mul_a = {4'd0, cos_flip_reg, 28'd0};
                mul_b = e_cl;
                if (!phase_reg) begin
                    mul_req.start = 1'b1;
                    phase_next    = 1'b1;
                end else if (mul_stat.done) begin
                    num32_next = num_full[60:28];
                    den32_next = (den_full[60:28] == 33'd0) ? 33'd1 : den_full[60:28];
                    phase_next = 1'b0;
                    state_next = ST_RATIO;
                end
            end
            ST_RATIO: begin
                if (num32_reg >= den32_reg) begin
                    ratio_next = 33'h1_0000_0000;
                    state_next = ST_SIG_MUL;
                end else begin
                    state_next = ST_RATIO_DIV;
                end
            end
            ST_RATIO_DIV: begin
                div_dvd = {num32_reg[31:0], 32'd0};
                div_dvs = den32_reg;
                if (!phase_reg) begin
                    div_start  = 1'b1;
                    phase_next = 1'b1;
                end else if (div_stat.done) begin
                    ratio_next = div_quo[32:0];
                    phase_next = 1'b0;
                    state_next = ST_SIG_MUL;
                end
            end
            ST_SIG_MUL: begin
                mul_a = {16'd0, scale_reg};
                mul_b = {31'd0, ratio_reg};
                mul_req.sh = SH_40;
                if (!phase_reg) begin
                    mul_req.start = 1'b1;
                    phase_next    = 1'b1;
                end else if (mul_stat.done) begin
                    if (mul_res[63:32] != 32'd0) begin
                        sig_next = {SIG_W{1'b1}};
                        sat_next = 1'b1;
                    end else begin
                        sig_next = mul_res[31:0];
                    end
                    phase_next = 1'b0;
                    state_next = ST_SUM_MUL;
                end
            end
            ST_SUM_MUL: begin
                mul_a = {15'd0, rs_plus};
                mul_b = {32'd0, decay_reg};
                mul_req.sh = SH_32;
                if (!phase_reg) begin
                    mul_req.start = 1'b1;
                    phase_next    = 1'b1;
                end else if (mul_stat.done) begin
                    if (mul_res[63:SUM_W] != '0) begin
                        rs_next  = {SUM_W{1'b1}};
                        sat_next = 1'b1;
                    end else begin
                        rs_next = mul_res[SUM_W-1:0];
                    end
                    phase_next = 1'b0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = sig_reg;
                    m_user_next  = sat_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            rs_reg      <= '0;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
            rs_reg      <= rs_next;
            idx_reg     <= idx_next;
        end
        cp_reg     <= cp_next;
        x_reg      <= x_next;
        term_reg   <= term_next;
        acc_reg    <= acc_next;
        e1_reg     <= e1_next;
        e60_reg    <= e60_next;
        k_reg      <= k_next;
        pass_reg   <= pass_next;
        whole_reg  <= whole_next;
        num32_reg  <= num32_next;
        den32_reg  <= den32_next;
        ratio_reg  <= ratio_next;
        sig_reg    <= sig_next;
        sat_reg    <= sat_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    // A unit is never restarted while it still works on an earlier operand.
    a_mul_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_req.start |-> !mul_stat.busy)
        else $error("multiplier started while busy");

    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // Both arithmetic units are quiet whenever a new sample can be taken.
    a_units_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!mul_stat.busy && !div_stat.busy))
        else $error("arithmetic unit busy while accepting a sample");

endmodule

/* tb/sv/dce_mri_signal_model_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dce_mri_signal_model_checker: scoreboard for the tissue signal model core.
// Watches the configuration, sample and result channels, predicts the signal
// of every accepted sample and compares each result transfer in order.
// ----------------------------------------------------------------------------
module dce_mri_signal_model_checker import dms_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [CP_W-1:0]      s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [SIG_W-1:0]     m_tdata,
    input  logic                 m_tuser,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output int                   fail_count,
    output int                   pending
);

    typedef struct packed {
        logic [SIG_W-1:0] signal;
        logic             saturated;
    } signal_t;

    signal_t signal_q[$];

    logic [31:0]       decay_r, base_rate_r, cos_flip_r;
    logic [39:0]       sum_gain_r, now_gain_r;
    logic [47:0]       scale_r;
    logic [IDX_W-1:0]  pre_count_r;
    logic [63:0]       sum_r;
    logic [IDX_W-1:0]  index_r;

    localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SUM_LIMIT = 64'h0000_FFFF_FFFF_FFFF;

    // floor(a*b / 2^s), saturated to 64 bits.
    function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        if ((p >> (64 + s)) != 0)
            return ALL_ONES;
        return p[63:0] >> s | p[127:64] << (64 - s);
    endfunction

    function automatic logic [63:0] add_clip(logic [63:0] a, logic [63:0] b);
        logic [64:0] r;
        r = {1'b0, a} + {1'b0, b};
        return r[64] ? ALL_ONES : r[63:0];
    endfunction

    // Truncated Taylor series of exp(-a), a in Q4.60 no larger than 1.0.
    function automatic logic [63:0] exp_neg(logic [63:0] a);
        logic [63:0] term, acc;
        term = ONE_Q60;
        acc  = ONE_Q60;
        for (int k = 1; k <= 20; k++) begin
            term = mul_shift(term, a, 60) / k;
            if (k % 2 == 1)
                acc = (term > acc) ? 64'd0 : acc - term;
            else
                acc = acc + term;
        end
        return acc;
    endfunction

    task automatic predict_signal(input logic [31:0] cp, input logic first,
                                  output signal_t res);
        logic [63:0] x, e60, e1, num, den, num32, den32, ratio, sig, t, ns;
        logic [63:0] whole;
        res.saturated = 1'b0;
        if (first) begin
            sum_r   = 0;
            index_r = 0;
        end
        if (index_r < ((pre_count_r > PRE_COUNT_MAX) ? PRE_COUNT_MAX : pre_count_r)) begin
            index_r++;
            res.signal = SIGNAL_ONE;
            return;
        end
        x = {32'd0, base_rate_r};
        x = add_clip(x, mul_shift({24'd0, sum_gain_r}, sum_r, 24));
        x = add_clip(x, mul_shift({24'd0, now_gain_r}, {32'd0, cp}, 24));
        if (x >= X_ZERO_LIMIT) begin
            e60 = 0;
        end else begin
            whole = x >> 32;
            e60 = exp_neg({32'd0, x[31:0]} << 28);
            e1 = exp_neg(ONE_Q60);
            for (int j = 0; j < whole; j++)
                e60 = mul_shift(e60, e1, 60);
        end
        if (e60 > ONE_Q60)
            e60 = ONE_Q60;
        num = ONE_Q60 - e60;
        den = ONE_Q60 - mul_shift({32'd0, cos_flip_r} << 28, e60, 60);
        num32 = num >> 28;
        den32 = den >> 28;
        if (den32 == 0)
            den32 = 1;
        if (num32 >= den32)
            ratio = 64'd1 << 32;
        else
            ratio = (num32 << 32) / den32;
        sig = mul_shift({16'd0, scale_r}, ratio, 40);
        if (sig > 64'hFFFF_FFFF) begin
            sig = 64'hFFFF_FFFF;
            res.saturated = 1'b1;
        end
        t = sum_r + cp;
        ns = mul_shift(t, {32'd0, decay_r}, 32);
        if (ns > SUM_LIMIT) begin
            ns = SUM_LIMIT;
            res.saturated = 1'b1;
        end
        sum_r = ns;
        res.signal = sig[31:0];
    endtask

    always @(posedge aclk) begin
        signal_t want;
        if (!aresetn) begin
            decay_r     <= 0;
            sum_gain_r  <= 0;
            now_gain_r  <= 0;
            base_rate_r <= 0;
            cos_flip_r  <= 0;
            scale_r     <= 0;
            pre_count_r <= 10'd5;
            sum_r       = 0;
            index_r     = 0;
            fail_count  <= 0;
            signal_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_DECAY:     decay_r     <= cfg_data[31:0];
                    REG_SUM_GAIN:  sum_gain_r  <= cfg_data[39:0];
                    REG_NOW_GAIN:  now_gain_r  <= cfg_data[39:0];
                    REG_BASE_RATE: base_rate_r <= cfg_data[31:0];
                    REG_COS_FLIP:  cos_flip_r  <= cfg_data[31:0];
                    REG_SCALE:     scale_r     <= cfg_data[47:0];
                    REG_PRE_COUNT: pre_count_r <= cfg_data[IDX_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                predict_signal(s_tdata, s_tuser, want);
                signal_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                if (signal_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result transfer: signal %h saturated %b",
                                 m_tdata, m_tuser);
                    fail_count <= fail_count + 1;
                end else begin
                    want = signal_q.pop_front();
                    if (m_tdata !== want.signal || m_tuser !== want.saturated) begin
                        if (fail_count < 10)
                            $display("mismatch: expected signal %h saturated %b, got %h %b",
                                     want.signal, want.saturated, m_tdata, m_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending <= signal_q.size();
    end

endmodule

/* tb/sv/dce_mri_signal_model_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dce_mri_signal_model_tb: stimulus and verdict for the tissue signal model.
// Runs directed corner series and then random series under several register
// settings, with random idling on both streams; the checker does the scoring.
// ----------------------------------------------------------------------------
module dce_mri_signal_model_tb;
    import dms_pkg::*;

    localparam int STALL_LIMIT = 40000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [CP_W-1:0]      s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [SIG_W-1:0]     m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data  = '0;
    int                   fail_count;
    int                   pending;

    bit quiet = 1'b0;
    int stall_left = 0;
    int idle_cycles = 0;
    int samples_sent = 0;

    always #10 aclk = ~aclk;

    dce_mri_signal_model dut (.*);
    dce_mri_signal_model_checker chk (.*);

    // Receiver back-pressure in bursts.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 14);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Ends the run if no channel moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_sample(input logic [31:0] cp, input logic first);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= cp;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
    endtask

    // Lets every expected result drain so that registers can change safely.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic load_model(input logic [47:0] decay, input logic [47:0] sum_gain,
                              input logic [47:0] now_gain, input logic [47:0] base_rate,
                              input logic [47:0] cos_flip, input logic [47:0] scale,
                              input logic [47:0] pre_count);
        drain();
        write_reg(REG_DECAY, decay);
        write_reg(REG_SUM_GAIN, sum_gain);
        write_reg(REG_NOW_GAIN, now_gain);
        write_reg(REG_BASE_RATE, base_rate);
        write_reg(REG_COS_FLIP, cos_flip);
        write_reg(REG_SCALE, scale);
        write_reg(REG_PRE_COUNT, pre_count);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Concentrations mostly in a physiological range, with some full-range values.
    function automatic logic [31:0] rand_cp();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'hFFFF_FFFF;
            2: return 32'd0;
            default: return $urandom_range(0, 32'h0400_0000);
        endcase
    endfunction

    initial begin
        int len, pre;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: five pre-injection samples, then all-zero gains.
        send_sample(32'd0, 1'b1);
        repeat (4) send_sample($urandom, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'd0, 1'b0);

        // Every register but the pre-injection count at its maximum: huge exponent and signal overflow.
        load_model(48'hFFFF_FFFF, 48'hFF_FFFF_FFFF, 48'hFF_FFFF_FFFF, 48'hFFFF_FFFF,
                   48'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'd0);
        send_sample(32'hFFFF_FFFF, 1'b1);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'd0, 1'b0);

        // Zero exponent with full flip cosine gives the smallest divisor for the signal ratio.
        load_model(48'd0, 48'd0, 48'd0, 48'd0, 48'hFFFF_FFFF, 48'd1 << 40, 48'd0);
        send_sample($urandom, 1'b1);
        send_sample(32'd0, 1'b0);

        // Longest pre-injection count, then lowered in the middle of a series.
        load_model(48'h8000_0000, 48'd1 << 32, 48'd1 << 32, 48'h4000_0000,
                   48'h8000_0000, 48'd1 << 32, 48'd1023);
        send_sample(rand_cp(), 1'b1);
        repeat (5) send_sample(rand_cp(), 1'b0);
        drain();
        write_reg(REG_PRE_COUNT, 48'd3);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        send_sample(32'h0100_0000, 1'b0);
        send_sample(rand_cp(), 1'b0);

        // Random settings and series; the last stretch runs without idling.
        while (samples_sent < 430) begin
            if (samples_sent > 380)
                quiet = 1'b1;
            pre = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 6);
            load_model(48'(rand64()), 48'(rand64() >> $urandom_range(8, 30)),
                       48'(rand64() >> $urandom_range(8, 30)), 48'($urandom),
                       48'($urandom), 48'(rand64() >> $urandom_range(0, 24)), 48'(pre));
            for (int s = 0; s < 4; s++) begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++) begin
                    // Mostly well-formed series; now and then a stray start flag.
                    if (i == 0)
                        send_sample(rand_cp(), $urandom_range(0, 9) != 0);
                    else
                        send_sample(rand_cp(), $urandom_range(0, 15) == 0);
                end
            end
        end

        drain();
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
